@@ design/rfsc_pkg.sv @@
// Shared types and constants for the feedback stream cipher.
package rfsc_pkg;

    localparam int KEY_BYTES_MAX_DEF = 32;
    localparam int TBL_DEPTH         = 256;
    localparam logic [7:0] IDX_LAST  = 8'hff;

    localparam logic [1:0] REQ_KEY = 2'd0;
    localparam logic [1:0] REQ_ENC = 2'd1;
    localparam logic [1:0] REQ_DEC = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_K_RD,
        ST_K_SUM1,
        ST_K_SUM2,
        ST_K_WRN,
        ST_K_WRA,
        ST_C_INC,
        ST_C_RDJ,
        ST_C_SWP1,
        ST_C_SWP2,
        ST_C_OUT
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_INC
    } t_alu_op;

    typedef struct packed {
        t_alu_op    op;
        logic [7:0] a;
        logic [7:0] b;
    } t_alu_req;

endpackage

@@ design/rfsc_alu.sv @@
// Shared 8-bit modulo-256 adder used by the key schedule sums and the cipher index sums.
module rfsc_alu
    import rfsc_pkg::*;
(
    input  t_alu_req   i_req,
    output logic [7:0] o_sum
);

    always_comb begin
        unique case (i_req.op)
            ALU_ADD: o_sum = i_req.a + i_req.b;
            ALU_INC: o_sum = i_req.a + 8'd1;
            default: o_sum = i_req.a;
        endcase
    end

endmodule

@@ design/rc4_feedback_stream_cipher.sv @@
// Top level: sequencer, permutation table, key store and output register.
//
// Input channel (i_in_valid / o_in_stall) carries one request per beat:
// load key byte, encrypt byte or decrypt byte. Output channel
// (o_out_valid / i_out_stall) returns one byte per encrypt or decrypt beat.
// Key loads and the unused request code return nothing.
// The key schedule and cipher sums go through one adder and one single-port-write,
// single-port-read table memory with registered read data.
// Key byte without the last mark: taken, and the block stays idle and ready.
// Key byte with the last mark: table fill, then the key schedule steps (read,
// two sums, two swap writes each), all done before the next beat is taken.
// Encrypt/decrypt: after accept, steps C_INC, C_RDJ, C_SWP1, C_SWP2 and C_OUT bring
// the result to the output register, following the chain of dependent table reads and the two swap writes.
// The input stalls while any item is in work.
// Reset clears the indices, feedback, key count and output valid; the table
// reads as all zeros until the first key schedule fills it.
// A stalled output holds its byte; a finished result waits in the last step
// until the output register frees, then the next beat can be taken.
module rc4_feedback_stream_cipher
    import rfsc_pkg::*;
#(
    parameter int KEY_BYTES_MAX = KEY_BYTES_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_key,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte
);

    localparam int KCW = $clog2(KEY_BYTES_MAX + 1);
    localparam int KIW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;

    t_state           r_state, n_state;
    logic [7:0]       r_i, n_i;
    logic [7:0]       r_j, n_j;
    logic [7:0]       r_fb, n_fb;
    logic [7:0]       r_si, n_si;
    logic [7:0]       r_t, n_t;
    logic [7:0]       r_acc, n_acc;
    logic [7:0]       r_n, n_n;
    logic [KCW-1:0]   r_key_count, n_key_count;
    logic [KIW-1:0]   r_kidx, n_kidx;
    logic [7:0]       r_key0, n_key0;
    logic             r_tbl_init, n_tbl_init;
    logic [1:0]       r_req, n_req;
    logic [7:0]       r_data, n_data;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;

    logic [7:0]       perm_mem [TBL_DEPTH];
    logic [7:0]       r_perm_rd;
    logic [7:0]       key_mem [KEY_BYTES_MAX];
    logic [7:0]       r_key_rd;

    logic             perm_rd_en;
    logic [7:0]       perm_ra;
    logic             perm_we;
    logic [7:0]       perm_wa;
    logic [7:0]       perm_wd;
    logic             key_rd_en;
    logic             key_we;
    logic [KIW-1:0]   key_wa;

    t_alu_req         alu_req;
    logic [7:0]       alu_sum;
    logic [7:0]       perm_q;
    logic [7:0]       ks;
    logic [7:0]       res;
    logic [KCW-1:0]   kidx_inc;
    logic             out_free;

    rfsc_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    // table reads as zero until the first schedule has filled it
    assign perm_q   = r_tbl_init ? r_perm_rd : 8'h00;
    assign kidx_inc = KCW'(r_kidx) + KCW'(1);
    assign out_free = !r_out_valid || !i_out_stall;
    // the swap of j was written in the same cycle the keystream read went out
    assign ks       = (r_t == r_j) ? r_si : perm_q;
    assign res      = r_data ^ ks ^ r_fb;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

    always_ff @(posedge i_clk) begin
        if (perm_we) begin
            perm_mem[perm_wa] <= perm_wd;
        end
        if (perm_rd_en) begin
            r_perm_rd <= perm_mem[perm_ra];
        end
        if (key_we) begin
            key_mem[key_wa] <= i_data_byte;
        end
        if (key_rd_en) begin
            r_key_rd <= key_mem[r_kidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= 8'h00;
            r_j         <= 8'h00;
            r_fb        <= 8'h00;
            r_key_count <= '0;
            r_tbl_init  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_fb        <= n_fb;
            r_key_count <= n_key_count;
            r_tbl_init  <= n_tbl_init;
            r_out_valid <= n_out_valid;
        end
        r_si       <= n_si;
        r_t        <= n_t;
        r_acc      <= n_acc;
        r_n        <= n_n;
        r_kidx     <= n_kidx;
        r_key0     <= n_key0;
        r_req      <= n_req;
        r_data     <= n_data;
        r_out_byte <= n_out_byte;
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_fb        = r_fb;
        n_si        = r_si;
        n_t         = r_t;
        n_acc       = r_acc;
        n_n         = r_n;
        n_key_count = r_key_count;
        n_kidx      = r_kidx;
        n_key0      = r_key0;
        n_tbl_init  = r_tbl_init;
        n_req       = r_req;
        n_data      = r_data;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;

        perm_rd_en = 1'b0;
        perm_ra    = r_n;
        perm_we    = 1'b0;
        perm_wa    = r_n;
        perm_wd    = r_n;
        key_rd_en  = 1'b0;
        key_we     = 1'b0;
        key_wa     = r_key_count[KIW-1:0];
        alu_req    = '{op: ALU_ADD, a: r_acc, b: r_key_rd};

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_req_type)
                        REQ_KEY: begin
                            if (r_key_count < KCW'(KEY_BYTES_MAX)) begin
                                key_we      = 1'b1;
                                n_key_count = r_key_count + KCW'(1);
                                if (r_key_count == '0) begin
                                    n_key0 = i_data_byte;
                                end
                            end
                            if (i_last_key) begin
                                n_n     = 8'h00;
                                n_state = ST_FILL;
                            end
                        end
                        REQ_ENC, REQ_DEC: begin
                            n_req   = i_req_type;
                            n_data  = i_data_byte;
                            n_state = ST_C_INC;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                perm_we = 1'b1;
                if (r_n == IDX_LAST) begin
                    n_n        = 8'h00;
                    n_acc      = 8'h00;
                    n_kidx     = '0;
                    n_tbl_init = 1'b1;
                    n_state    = ST_K_RD;
                end else begin
                    n_n = r_n + 8'd1;
                end
            end
            ST_K_RD: begin
                perm_rd_en = 1'b1;
                key_rd_en  = 1'b1;
                n_state    = ST_K_SUM1;
            end
            ST_K_SUM1: begin
                n_si    = perm_q;
                alu_req = '{op: ALU_ADD, a: r_acc, b: r_key_rd};
                n_acc   = alu_sum;
                n_state = ST_K_SUM2;
            end
            ST_K_SUM2: begin
                alu_req    = '{op: ALU_ADD, a: r_acc, b: r_si};
                n_acc      = alu_sum;
                perm_rd_en = 1'b1;
                perm_ra    = alu_sum;
                n_state    = ST_K_WRN;
            end
            ST_K_WRN: begin
                perm_we = 1'b1;
                perm_wa = r_n;
                perm_wd = perm_q;
                n_state = ST_K_WRA;
            end
            ST_K_WRA: begin
                perm_we = 1'b1;
                perm_wa = r_acc;
                perm_wd = r_si;
                // key bytes repeat cyclically over the stored length
                if (kidx_inc == r_key_count) begin
                    n_kidx = '0;
                end else begin
                    n_kidx = kidx_inc[KIW-1:0];
                end
                if (r_n == IDX_LAST) begin
                    n_fb        = r_key0;
                    n_i         = 8'h00;
                    n_j         = 8'h00;
                    n_key_count = '0;
                    n_state     = ST_IDLE;
                end else begin
                    n_n     = r_n + 8'd1;
                    n_state = ST_K_RD;
                end
            end
            ST_C_INC: begin
                alu_req    = '{op: ALU_INC, a: r_i, b: 8'h00};
                n_i        = alu_sum;
                perm_rd_en = 1'b1;
                perm_ra    = alu_sum;
                n_state    = ST_C_RDJ;
            end
            ST_C_RDJ: begin
                n_si       = perm_q;
                alu_req    = '{op: ALU_ADD, a: r_j, b: perm_q};
                n_j        = alu_sum;
                perm_rd_en = 1'b1;
                perm_ra    = alu_sum;
                n_state    = ST_C_SWP1;
            end
            ST_C_SWP1: begin
                perm_we = 1'b1;
                perm_wa = r_i;
                perm_wd = perm_q;
                alu_req = '{op: ALU_ADD, a: r_si, b: perm_q};
                n_t     = alu_sum;
                n_state = ST_C_SWP2;
            end
            ST_C_SWP2: begin
                perm_we    = 1'b1;
                perm_wa    = r_j;
                perm_wd    = r_si;
                perm_rd_en = 1'b1;
                perm_ra    = r_t;
                n_state    = ST_C_OUT;
            end
            ST_C_OUT: begin
                if (out_free) begin
                    n_out_byte  = res;
                    n_out_valid = 1'b1;
                    n_fb        = r_fb ^ ((r_req == REQ_ENC) ? r_data : res);
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_cipher_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_req_type == REQ_ENC || i_req_type == REQ_DEC))
        |=> (r_state == ST_C_INC))
        else $error("cipher beat did not start the step sequence");

    a_key_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= KCW'(KEY_BYTES_MAX))
        else $error("key count beyond key store size");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_C_OUT && out_free) |=> (o_out_valid && r_state == ST_IDLE))
        else $error("finished result not delivered to output register");

    a_kidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_K_RD) |-> (KCW'(r_kidx) < r_key_count))
        else $error("key index outside stored key length");

    a_table_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_K_RD) |-> r_tbl_init)
        else $error("key schedule running on an unfilled table");

endmodule

@@ tb/rc4_feedback_stream_cipher_test.sv @@
// Self-checking testbench for the feedback stream cipher, with predictor and scoreboard.
module rc4_feedback_stream_cipher_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rfsc_pkg::*;

    localparam int KEY_MAX = KEY_BYTES_MAX_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 650;
    localparam int QUIET_AFTER = 590;

    // Tracks cipher state beat by beat and holds the output bytes still owed.
    class rc4_fb_scoreboard;
        logic [7:0] perm [256];
        logic [7:0] keys [KEY_MAX];
        int unsigned key_cnt;
        logic [7:0] idx_i;
        logic [7:0] idx_j;
        logic [7:0] fb;
        logic [7:0] owed_bytes [$];
        int errors;

        function new();
            foreach (perm[n]) perm[n] = 8'h00;
            foreach (keys[n]) keys[n] = 8'h00;
            key_cnt = 0;
            idx_i = 8'h00;
            idx_j = 8'h00;
            fb = 8'h00;
            errors = 0;
        endfunction

        function void rekey(int unsigned len);
            logic [7:0] acc;
            logic [7:0] t;
            acc = 8'h00;
            for (int n = 0; n < 256; n++) perm[n] = n[7:0];
            for (int n = 0; n < 256; n++) begin
                acc = acc + keys[n % len] + perm[n];
                t = perm[n];
                perm[n] = perm[acc];
                perm[acc] = t;
            end
            fb = keys[0];
            idx_i = 8'h00;
            idx_j = 8'h00;
        endfunction

        function logic [7:0] advance_stream();
            logic [7:0] t;
            logic [7:0] sum;
            idx_i = idx_i + 8'd1;
            idx_j = idx_j + perm[idx_i];
            t = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = t;
            sum = perm[idx_i] + perm[idx_j];
            return perm[sum];
        endfunction

        function void note_beat(logic [1:0] req, logic [7:0] d, logic last);
            logic [7:0] res;
            case (req)
                REQ_KEY: begin
                    if (key_cnt < KEY_MAX) begin
                        keys[key_cnt] = d;
                        key_cnt++;
                    end
                    if (last) begin
                        rekey(key_cnt);
                        key_cnt = 0;
                    end
                end
                REQ_ENC, REQ_DEC: begin
                    res = d ^ advance_stream() ^ fb;
                    // feedback always folds in the plaintext side
                    fb = fb ^ ((req == REQ_ENC) ? d : res);
                    owed_bytes.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_byte(logic [7:0] got);
            logic [7:0] want;
            if (owed_bytes.size() == 0) begin
                errors++;
                $display("%0t: out_byte with no beat pending, expected none, actual %02h",
                         $time, got);
            end else begin
                want = owed_bytes.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, want, got);
                end
            end
        endfunction

        function int pending();
            return owed_bytes.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_req_type  = REQ_KEY;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_key  = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_out_byte;

    rc4_fb_scoreboard sb;
    int  stim_count = 0;
    bit  quiet = 1'b0;

    rc4_feedback_stream_cipher #(
        .KEY_BYTES_MAX(KEY_MAX)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .i_last_key  (i_last_key),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Sends one beat, with an optional idle burst of junk payload first.
    task automatic send_beat(input logic [1:0] req, input logic [7:0] d, input logic last);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) begin
                i_req_type  <= 2'($urandom_range(0, 3));
                i_data_byte <= 8'($urandom_range(0, 255));
                i_last_key  <= 1'($urandom_range(0, 1));
                @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_data_byte <= d;
        i_last_key  <= last;
        do @(posedge i_clk); while (o_in_stall);
        if (req != REQ_UNUSED && !(req == REQ_KEY && sb.key_cnt >= KEY_MAX))
            stim_count++;
        sb.note_beat(req, d, last);
        if (stim_count > QUIET_AFTER) quiet = 1'b1;
    endtask

    task automatic load_key(input int len);
        for (int k = 0; k < len; k++)
            send_beat(REQ_KEY, 8'($urandom_range(0, 255)), k == len - 1);
    endtask

    // Receiver side: stall in random bursts until the quiet tail.
    initial begin
        int n;
        forever begin
            if (quiet) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 10);
                i_out_stall <= ($urandom_range(0, 2) == 0);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_byte(o_out_byte);
        end
    end

    initial begin
        int seq;
        int nd;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cipher on the all-zero table, mark on data beats, unused code
        send_beat(REQ_ENC, 8'h00, 1'b0);
        send_beat(REQ_ENC, 8'hff, 1'b1);
        send_beat(REQ_DEC, 8'h5a, 1'b0);
        send_beat(REQ_UNUSED, 8'hff, 1'b1);
        send_beat(REQ_DEC, 8'h00, 1'b0);
        // one-byte key
        send_beat(REQ_KEY, 8'hff, 1'b1);
        send_beat(REQ_ENC, 8'hff, 1'b0);
        send_beat(REQ_DEC, 8'h00, 1'b0);
        send_beat(REQ_ENC, 8'h3c, 1'b0);
        // unused code between key bytes leaves the key count alone
        send_beat(REQ_KEY, 8'h00, 1'b0);
        send_beat(REQ_KEY, 8'h80, 1'b0);
        send_beat(REQ_UNUSED, 8'h11, 1'b0);
        send_beat(REQ_KEY, 8'h7f, 1'b1);
        send_beat(REQ_DEC, 8'hff, 1'b0);
        send_beat(REQ_ENC, 8'h00, 1'b1);
        send_beat(REQ_DEC, 8'ha5, 1'b0);
        send_beat(REQ_ENC, 8'h5a, 1'b0);
        send_beat(REQ_KEY, 8'h00, 1'b1);
        send_beat(REQ_ENC, 8'hff, 1'b0);
        send_beat(REQ_DEC, 8'hff, 1'b0);

        seq = 0;
        while (stim_count < ITEM_TARGET) begin
            seq++;
            if ($urandom_range(0, 4) != 0) begin
                // a key load whose sequence number is 3 mod 6 overflows the key store
                load_key((seq % 6 == 3) ? $urandom_range(KEY_MAX + 1, KEY_MAX + 8)
                                        : $urandom_range(1, 16));
                nd = $urandom_range(1, 30);
                repeat (nd)
                    send_beat($urandom_range(0, 1) ? REQ_ENC : REQ_DEC,
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                // noise: any code, rare schedule starts, partial keys carry over
                repeat ($urandom_range(1, 12))
                    send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              $urandom_range(0, 7) == 0);
            end
        end
        i_in_valid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/rfsc_pkg.sv
design/rfsc_alu.sv
design/rc4_feedback_stream_cipher.sv
tb/rc4_feedback_stream_cipher_test.sv
